// ===== rtl/core/xbcf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xbcf_pkg
// Types and constants shared by the x86 branch call filter modules.
// ----------------------------------------------------------------------------
package xbcf_pkg;

  localparam int unsigned WINDOW_DEPTH = 5;

  localparam logic [7:0] OPCODE_MASK  = 8'hFE;
  localparam logic [7:0] OPCODE_CALL  = 8'hE8;
  localparam logic [7:0] EDGE_LOW     = 8'h00;
  localparam logic [7:0] EDGE_HIGH    = 8'hFF;

  // Configuration register indexes
  localparam logic REG_ENCODE_MODE   = 1'b0;
  localparam logic REG_START_ADDRESS = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_final;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // write the accepted byte into the window
    logic skip;        // oldest byte stays unconverted: update mask and position
    logic calc_cur;    // form start address plus position plus five
    logic add_first;   // first relative/absolute conversion
    logic add_second;  // correction and write-back of the operand
    logic pop;         // move the oldest byte into the output register
    logic pop_final;   // the popped byte is the last of this request
    logic clear_end;   // end of stream: mask and position return to zero
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       full;
    logic       convert;
    logic [2:0] fill;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/core/xbcf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xbcf_ctrl
// Sequencer: accepts a request, decides the oldest window byte, runs the
// operand conversion and drains the bytes that the request releases.
// ----------------------------------------------------------------------------
module xbcf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               byte_valid,
  input  wire               end_of_stream,
  output logic              byte_stall,
  input  xbcf_pkg::status_t status,
  output xbcf_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CUR    = 3'd2;
  localparam logic [2:0] S_ADD1   = 3'd3;
  localparam logic [2:0] S_ADD2   = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;

  localparam logic [2:0] POPS_CONVERT = 3'd5;
  localparam logic [2:0] POPS_SKIP    = 3'd1;

  logic [2:0] state, state_next;
  logic [2:0] pops, pops_next;
  logic       eos, eos_next;
  logic       accept;

  assign byte_stall = (state != S_IDLE);
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    state_next = state;
    pops_next  = pops;
    eos_next   = eos;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          eos_next   = end_of_stream;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.convert) begin
          state_next = S_CUR;
        end else begin
          cmd.skip = status.full;
          if (eos) begin
            // Everything still held goes out unchanged.
            pops_next  = status.fill;
            state_next = S_POP;
          end else if (status.full) begin
            pops_next  = POPS_SKIP;
            state_next = S_POP;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_CUR: begin
        cmd.calc_cur = 1'b1;
        state_next   = S_ADD1;
      end
      S_ADD1: begin
        cmd.add_first = 1'b1;
        state_next    = S_ADD2;
      end
      S_ADD2: begin
        cmd.add_second = 1'b1;
        pops_next      = POPS_CONVERT;
        state_next     = S_POP;
      end
      S_POP: begin
        if (status.out_free) begin
          cmd.pop       = 1'b1;
          cmd.pop_final = (pops == 3'd1);
          pops_next     = pops - 3'd1;
          if (pops == 3'd1) begin
            cmd.clear_end = eos;
            state_next    = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pops  <= 3'd0;
      eos   <= 1'b0;
    end else begin
      state <= state_next;
      pops  <= pops_next;
      eos   <= eos_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/xbcf_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xbcf_datapath
// Five-byte window, opcode mask, stream position, configuration registers,
// operand converter and output register.
// ----------------------------------------------------------------------------
module xbcf_datapath (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire                 cfg_index,
  input  wire  [31:0]         cfg_data,
  input  wire  [7:0]          data_byte,
  input  xbcf_pkg::cmd_t      cmd,
  output xbcf_pkg::status_t   status,
  input  wire                 result_stall,
  output logic                result_valid,
  output xbcf_pkg::out_item_t result_item
);

  logic [7:0]  win [xbcf_pkg::WINDOW_DEPTH];
  logic [2:0]  fill;
  logic [2:0]  mask;
  logic [31:0] pos;
  logic [31:0] cur;
  logic [31:0] val;
  logic        encode_mode;
  logic [31:0] start_address;

  logic        is_op;
  logic        veto;
  logic [2:0]  probe_idx;
  logic [31:0] operand;
  logic [7:0]  probe_byte;
  logic [31:0] flip;
  logic [31:0] val_fixed;
  logic [31:0] val_final;

  function automatic logic edge_byte(input logic [7:0] b);
    return (b == xbcf_pkg::EDGE_LOW) || (b == xbcf_pkg::EDGE_HIGH);
  endfunction

  function automatic logic [31:0] shift_addr(input logic enc, input logic [31:0] v,
                                             input logic [31:0] c);
    return enc ? v + c : v - c;
  endfunction

  assign is_op     = (win[0] & xbcf_pkg::OPCODE_MASK) == xbcf_pkg::OPCODE_CALL;
  assign probe_idx = {1'b0, mask[2:1]} + 3'd1;
  assign veto      = (mask > 3'd4) || (mask == 3'd3) ||
                     ((mask != 3'd0) && edge_byte(win[probe_idx])) ||
                     !edge_byte(win[4]);
  assign operand   = {win[4], win[3], win[2], win[1]};

  assign status.full     = (fill == 3'd5);
  assign status.convert  = status.full && is_op && !veto;
  assign status.fill     = fill;
  assign status.out_free = !result_valid || !result_stall;

  // The correction looks at the byte picked by the mask. When the mask is nonzero and that
  // byte is an edge byte, it flips every bit below and including it before converting a second time.
  always_comb begin
    case (mask[2:1])
      2'd0: begin
        probe_byte = val[7:0];
        flip       = 32'h0000_00FF;
      end
      2'd1: begin
        probe_byte = val[15:8];
        flip       = 32'h0000_FFFF;
      end
      default: begin
        probe_byte = val[23:16];
        flip       = 32'h00FF_FFFF;
      end
    endcase
    val_fixed = shift_addr(encode_mode, val ^ flip, cur);
    val_final = ((mask != 3'd0) && edge_byte(probe_byte)) ? val_fixed : val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      encode_mode   <= 1'b0;
      start_address <= 32'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        xbcf_pkg::REG_ENCODE_MODE:   encode_mode   <= cfg_data[0];
        xbcf_pkg::REG_START_ADDRESS: start_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 3'd0;
      mask <= 3'd0;
      pos  <= 32'd0;
    end else begin
      if (cmd.load) begin
        fill <= fill + 3'd1;
      end
      if (cmd.skip) begin
        mask <= {is_op, mask[2:1]};
        pos  <= pos + 32'd1;
      end
      if (cmd.add_second) begin
        mask <= 3'd0;
        pos  <= pos + 32'd5;
      end
      if (cmd.pop) begin
        fill <= fill - 3'd1;
      end
      if (cmd.clear_end) begin
        mask <= 3'd0;
        pos  <= 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win[fill] <= data_byte;
    end
    if (cmd.calc_cur) begin
      cur <= start_address + pos + 32'd5;
    end
    if (cmd.add_first) begin
      val <= shift_addr(encode_mode, operand, cur);
    end
    if (cmd.add_second) begin
      win[1] <= val_final[7:0];
      win[2] <= val_final[15:8];
      win[3] <= val_final[23:16];
      win[4] <= {8{val_final[24]}};
    end
    if (cmd.pop) begin
      for (int i = 0; i < xbcf_pkg::WINDOW_DEPTH - 1; i++) begin
        win[i] <= win[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      result_item.out_byte  <= win[0];
      result_item.out_final <= cmd.pop_final;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/x86_branch_call_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// x86_branch_call_filter
// Byte-stream converter for x86 CALL/JMP operands between relative and
// absolute form, with a five-byte look-ahead window.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE and decided in S_DECIDE; a converted branch then passes
// through S_CUR, S_ADD1 and S_ADD2 in the adder chain. Each released byte is popped into
// the output register in S_POP once that register is free, and the output register
// lets the next request in while it waits.
// Synchronous active-high reset empties the window and clears the mask, the position
// and both configuration registers.
module x86_branch_call_filter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire                 cfg_index,
  input  wire  [31:0]         cfg_data,
  input  wire                 byte_valid,
  output logic                byte_stall,
  input  xbcf_pkg::in_item_t  byte_item,
  output logic                result_valid,
  input  wire                 result_stall,
  output xbcf_pkg::out_item_t result_item
);

  xbcf_pkg::cmd_t    cmd;
  xbcf_pkg::status_t status;

  xbcf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .end_of_stream (byte_item.end_of_stream),
    .byte_stall    (byte_stall),
    .status        (status),
    .cmd           (cmd)
  );

  xbcf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (byte_item.data_byte),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_item  (result_item)
  );

endmodule
`default_nettype wire

// ===== rtl/core/xbcf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xbcf_checker
// Port-level checks on the x86 branch call filter.
// ----------------------------------------------------------------------------
module xbcf_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 byte_valid,
  input wire                 byte_stall,
  input wire                 result_valid,
  input wire                 result_stall,
  input xbcf_pkg::out_item_t result_item
);

  // A held result must stay put until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("result changed while stalled");

  // After a request is taken the block is busy deciding it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |=> byte_stall)
    else $error("request accepted without a decide cycle");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // A fresh result cannot appear while idle with nothing in flight: each new
  // result follows a busy cycle.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    !result_valid ##1 result_valid |-> $past(byte_stall))
    else $error("result appeared without work in progress");

endmodule

bind x86_branch_call_filter xbcf_checker u_xbcf_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
`default_nettype wire

// ===== tb/x86_branch_call_filter_checker.sv =====
// ----------------------------------------------------------------------------
// x86_branch_call_filter_checker
// Watches both byte channels and the register port of the branch call filter,
// predicts the converted stream from every accepted request and compares each
// released byte, in order, against the prediction.
// ----------------------------------------------------------------------------
module x86_branch_call_filter_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire                 cfg_index,
  input  wire [31:0]          cfg_data,
  input  wire                 byte_valid,
  input  wire                 byte_stall,
  input  xbcf_pkg::in_item_t  byte_item,
  input  wire                 result_valid,
  input  wire                 result_stall,
  input  xbcf_pkg::out_item_t result_item,
  input  wire                 run_done,
  output int                  fail_count,
  output int                  pending,
  output int                  requests_seen,
  output int                  results_seen,
  output int                  branches_converted
);

  // Predicted copy of the filter state and registers
  logic [7:0]  held [xbcf_pkg::WINDOW_DEPTH];
  int          held_count;
  logic [2:0]  opcode_history;
  logic [31:0] stream_offset;
  logic        encode_on;
  logic [31:0] base_address;

  xbcf_pkg::out_item_t expected_bytes [$];
  int          released_now;
  bit          leftovers_checked;

  initial begin
    fail_count         = 0;
    pending            = 0;
    requests_seen      = 0;
    results_seen       = 0;
    branches_converted = 0;
    leftovers_checked  = 1'b0;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  function automatic logic is_edge(input logic [7:0] b);
    return b == xbcf_pkg::EDGE_LOW || b == xbcf_pkg::EDGE_HIGH;
  endfunction

  function automatic logic [31:0] rebase(input logic [31:0] v, input logic [31:0] cur);
    return encode_on ? v + cur : v - cur;
  endfunction

  task automatic release_byte(input logic [7:0] b);
    xbcf_pkg::out_item_t item;
    item.out_byte  = b;
    item.out_final = 1'b0;
    expected_bytes.push_back(item);
    released_now++;
  endtask

  task automatic drop_oldest();
    for (int i = 0; i < xbcf_pkg::WINDOW_DEPTH - 1; i++)
      held[i] = held[i + 1];
    held_count    = xbcf_pkg::WINDOW_DEPTH - 1;
    stream_offset = stream_offset + 32'd1;
  endtask

  // The window is full: settle the fate of its oldest byte.
  task automatic decide_oldest();
    logic [2:0]  m;
    logic [7:0]  head;
    logic [31:0] operand;
    logic [31:0] cur;
    int          sh;
    m    = opcode_history;
    head = held[0];
    if ((head & xbcf_pkg::OPCODE_MASK) != xbcf_pkg::OPCODE_CALL) begin
      release_byte(head);
      opcode_history = m >> 1;
      drop_oldest();
    end else if (m > 3'd4 || m == 3'd3 || (m != 3'd0 && is_edge(held[(m >> 1) + 1])) ||
                 !is_edge(held[4])) begin
      release_byte(head);
      opcode_history = (m >> 1) | 3'd4;
      drop_oldest();
    end else begin
      operand = {held[4], held[3], held[2], held[1]};
      cur     = base_address + stream_offset + 32'd5;
      operand = rebase(operand, cur);
      if (m != 3'd0) begin
        sh = int'(m & 3'd6) * 4;
        // An edge byte at the history position forces a second pass.
        if (is_edge(8'(operand >> sh))) begin
          operand = operand ^ ((32'h100 << sh) - 32'd1);
          operand = rebase(operand, cur);
        end
      end
      release_byte(head);
      release_byte(operand[7:0]);
      release_byte(operand[15:8]);
      release_byte(operand[23:16]);
      release_byte(operand[24] ? xbcf_pkg::EDGE_HIGH : xbcf_pkg::EDGE_LOW);
      opcode_history = 3'd0;
      held_count     = 0;
      stream_offset  = stream_offset + 32'd5;
      branches_converted++;
    end
  endtask

  task automatic convert_request(input xbcf_pkg::in_item_t req);
    released_now     = 0;
    held[held_count] = req.data_byte;
    held_count++;
    if (held_count == xbcf_pkg::WINDOW_DEPTH)
      decide_oldest();
    if (req.end_of_stream) begin
      for (int i = 0; i < held_count; i++)
        release_byte(held[i]);
      held_count     = 0;
      opcode_history = 3'd0;
      stream_offset  = 32'd0;
    end
    if (released_now > 0)
      expected_bytes[$].out_final = 1'b1;
  endtask

  always @(posedge clk) begin
    xbcf_pkg::out_item_t want;
    if (rst) begin
      held_count     = 0;
      opcode_history = 3'd0;
      stream_offset  = 32'd0;
      encode_on      = 1'b0;
      base_address   = 32'd0;
      expected_bytes.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_bytes.size() == 0) begin
          report($sformatf("result byte %02h (last %0b) with nothing expected",
                           result_item.out_byte, result_item.out_final));
        end else begin
          want = expected_bytes.pop_front();
          if (result_item.out_byte != want.out_byte ||
              result_item.out_final != want.out_final)
            report($sformatf("result %0d: byte %02h last %0b, expected byte %02h last %0b",
                             results_seen, result_item.out_byte, result_item.out_final,
                             want.out_byte, want.out_final));
        end
        results_seen++;
      end
      if (byte_valid && !byte_stall) begin
        convert_request(byte_item);
        requests_seen++;
      end
      if (cfg_write) begin
        if (cfg_index == xbcf_pkg::REG_ENCODE_MODE)
          encode_on = cfg_data[0];
        else
          base_address = cfg_data;
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_bytes.size() != 0)
          report($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// ===== tb/x86_branch_call_filter_tb.sv =====
// ----------------------------------------------------------------------------
// x86_branch_call_filter_tb
// Drives byte streams into the branch call filter under several idle and
// stall patterns and register settings; a checker beside the block predicts
// and compares every released byte.
// ----------------------------------------------------------------------------
module x86_branch_call_filter_tb;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic                cfg_index;
  logic [31:0]         cfg_data;
  logic                byte_valid;
  logic                byte_stall;
  xbcf_pkg::in_item_t  byte_item;
  logic                result_valid;
  logic                result_stall = 1'b0;
  xbcf_pkg::out_item_t result_item;
  logic                run_done;

  int fail_count;
  int pending;
  int requests_seen;
  int results_seen;
  int branches_converted;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int items_sent   = 0;

  int gap_by_phase   [4] = '{0, 77, 0, 16};
  int stall_by_phase [4] = '{0, 0, 77, 16};

  logic [7:0] stream_q [$];

  x86_branch_call_filter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  x86_branch_call_filter_checker filter_check (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .byte_valid         (byte_valid),
    .byte_stall         (byte_stall),
    .byte_item          (byte_item),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .result_item        (result_item),
    .run_done           (run_done),
    .fail_count         (fail_count),
    .pending            (pending),
    .requests_seen      (requests_seen),
    .results_seen       (results_seen),
    .branches_converted (branches_converted)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Returns at the rising edge that accepted the request; valid stays high
  // until the next request decides whether to idle.
  task automatic send_byte(input logic [7:0] b, input logic last);
    xbcf_pkg::in_item_t req;
    req.data_byte     = b;
    req.end_of_stream = last;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_item  <= req;
    byte_valid <= 1'b1;
    @(posedge clk);
    while (byte_stall)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  function automatic logic [7:0] operand_byte();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? xbcf_pkg::EDGE_HIGH : xbcf_pkg::EDGE_LOW;
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed branches with random operands, mixed with lone
  // opcodes, edge bytes and plain noise.
  task automatic build_random_stream();
    int target;
    int pick;
    target = $urandom_range(24, 1);
    stream_q.delete();
    while (stream_q.size() < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        stream_q.push_back(xbcf_pkg::OPCODE_CALL | 8'($urandom_range(1)));
        repeat (3) stream_q.push_back(operand_byte());
        if ($urandom_range(9) == 0)
          stream_q.push_back(8'($urandom_range(255)));
        else
          stream_q.push_back($urandom_range(1) ? xbcf_pkg::EDGE_HIGH : xbcf_pkg::EDGE_LOW);
      end else if (pick < 65) begin
        stream_q.push_back(xbcf_pkg::OPCODE_CALL | 8'($urandom_range(1)));
      end else if (pick < 80) begin
        stream_q.push_back($urandom_range(1) ? xbcf_pkg::EDGE_HIGH : xbcf_pkg::EDGE_LOW);
      end else begin
        stream_q.push_back(8'($urandom_range(255)));
      end
    end
  endtask

  // Requests that cause no byte may still be in flight once the queue is
  // empty, so allow the block's worst request time on top.
  task automatic wait_idle();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  initial begin
    int phase_start;
    int drain_cycles;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = xbcf_pkg::REG_ENCODE_MODE;
    cfg_data   = 32'd0;
    byte_valid = 1'b0;
    byte_item  = '0;
    run_done   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(xbcf_pkg::REG_ENCODE_MODE, 32'd1);
    write_reg(xbcf_pkg::REG_START_ADDRESS, 32'h0040_1000);

    // Streams shorter than the window pass straight through.
    stream_q = '{8'hFF};
    send_stream();
    stream_q = '{8'hE8, 8'h00, 8'hFF};
    send_stream();
    // A call whose operand ends in 00, closing the stream on its last byte.
    stream_q = '{8'hE8, 8'h78, 8'h56, 8'h34, 8'h00};
    send_stream();
    // A jump ending in FF, then a call vetoed by a non-edge top byte.
    stream_q = '{8'hE9, 8'h10, 8'h20, 8'h30, 8'hFF, 8'hE8, 8'h11, 8'h22, 8'h33, 8'h44};
    send_stream();
    // A vetoed opcode sets the history, which then steers the next conversion.
    stream_q = '{8'hE8, 8'hE9, 8'h12, 8'h34, 8'h56, 8'h00, 8'h00};
    send_stream();

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(xbcf_pkg::REG_ENCODE_MODE, 32'd1);
          write_reg(xbcf_pkg::REG_START_ADDRESS, 32'h0000_0000);
        end
        1: begin
          write_reg(xbcf_pkg::REG_ENCODE_MODE, 32'd0);
          write_reg(xbcf_pkg::REG_START_ADDRESS, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(xbcf_pkg::REG_ENCODE_MODE, 32'd1);
          write_reg(xbcf_pkg::REG_START_ADDRESS, 32'hFFFF_FFFB);
        end
        default: begin
          write_reg(xbcf_pkg::REG_ENCODE_MODE, 32'd0);
          write_reg(xbcf_pkg::REG_START_ADDRESS, $urandom);
        end
      endcase
      send_gap_pct = gap_by_phase[p];
      stall_pct    = stall_by_phase[p];
      phase_start  = items_sent;
      while (items_sent - phase_start < 32) begin
        build_random_stream();
        send_stream();
      end
    end

    @(negedge clk);
    byte_valid <= 1'b0;
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 5000) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (20) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Streamed %0d bytes and checked %0d released bytes; %0d branch operands converted.",
             requests_seen, results_seen, branches_converted);
    $display("Covered free-running, sender-idle, receiver-stall and mixed phases in both modes.");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
